// ----- design/u2c_pkg.sv -----
// Shared types and constants for the UTF-8 to CP437 transcoder.
// Holds the result kind codes, the decode descriptor and the CP437 code point table.
// No dependencies.
package u2c_pkg;

  typedef enum logic [1:0] {
    KIND_GLYPH   = 2'd0,
    KIND_NEWLINE = 2'd1,
    KIND_NONE    = 2'd2
  } kind_e;

  localparam int unsigned CpWidth = 21;

  // Results caused by one byte: an optional leading no-glyph result, then
  // a main result that is either a code point to look up or a no-glyph.
  typedef struct packed {
    logic               any;
    logic               two;
    logic               is_cp;
    logic [CpWidth-1:0] cp;
  } u2c_res_t;

  localparam logic [7:0] ContMask  = 8'hc0;
  localparam logic [7:0] ContMark  = 8'h80;
  localparam logic [7:0] Lead2Mask = 8'he0;
  localparam logic [7:0] Lead3Mask = 8'hf0;
  localparam logic [7:0] Lead3Mark = 8'he0;
  localparam logic [7:0] Lead4Mask = 8'hf8;
  localparam logic [7:0] Lead4Mark = 8'hf0;
  localparam logic [7:0] Lead2Bits = 8'h1f;
  localparam logic [7:0] Lead3Bits = 8'h0f;
  localparam logic [7:0] Lead4Bits = 8'h07;
  localparam logic [7:0] ContBits  = 8'h3f;
  localparam logic [CpWidth-1:0] NewlineCp = 21'd10;

  localparam logic [15:0] GLYPH_CP [256] = '{
    16'h0000, 16'h263A, 16'h263B, 16'h2665, 16'h2666, 16'h2663, 16'h2660, 16'h2022,
    16'h25D8, 16'h25CB, 16'h25D9, 16'h2642, 16'h2640, 16'h266A, 16'h266B, 16'h263C,
    16'h25BA, 16'h25C4, 16'h2195, 16'h203C, 16'h00B6, 16'h00A7, 16'h25AC, 16'h21A8,
    16'h2191, 16'h2193, 16'h2192, 16'h2190, 16'h221F, 16'h2194, 16'h25B2, 16'h25BC,
    16'h0020, 16'h0021, 16'h0022, 16'h0023, 16'h0024, 16'h0025, 16'h0026, 16'h0027,
    16'h0028, 16'h0029, 16'h002A, 16'h002B, 16'h002C, 16'h002D, 16'h002E, 16'h002F,
    16'h0030, 16'h0031, 16'h0032, 16'h0033, 16'h0034, 16'h0035, 16'h0036, 16'h0037,
    16'h0038, 16'h0039, 16'h003A, 16'h003B, 16'h003C, 16'h003D, 16'h003E, 16'h003F,
    16'h0040, 16'h0041, 16'h0042, 16'h0043, 16'h0044, 16'h0045, 16'h0046, 16'h0047,
    16'h0048, 16'h0049, 16'h004A, 16'h004B, 16'h004C, 16'h004D, 16'h004E, 16'h004F,
    16'h0050, 16'h0051, 16'h0052, 16'h0053, 16'h0054, 16'h0055, 16'h0056, 16'h0057,
    16'h0058, 16'h0059, 16'h005A, 16'h005B, 16'h005C, 16'h005D, 16'h005E, 16'h005F,
    16'h0060, 16'h0061, 16'h0062, 16'h0063, 16'h0064, 16'h0065, 16'h0066, 16'h0067,
    16'h0068, 16'h0069, 16'h006A, 16'h006B, 16'h006C, 16'h006D, 16'h006E, 16'h006F,
    16'h0070, 16'h0071, 16'h0072, 16'h0073, 16'h0074, 16'h0075, 16'h0076, 16'h0077,
    16'h0078, 16'h0079, 16'h007A, 16'h007B, 16'h007C, 16'h007D, 16'h007E, 16'h007F,
    16'h00C7, 16'h00FC, 16'h00E9, 16'h00E2, 16'h00E4, 16'h00E0, 16'h00E5, 16'h00E7,
    16'h00EA, 16'h00EB, 16'h00E8, 16'h00EF, 16'h00EE, 16'h00EC, 16'h00C4, 16'h00C5,
    16'h00C9, 16'h00E6, 16'h00C6, 16'h00F4, 16'h00F6, 16'h00F2, 16'h00FB, 16'h00F9,
    16'h00FF, 16'h00D6, 16'h00DC, 16'h00A2, 16'h00A3, 16'h00A5, 16'h20A7, 16'h0192,
    16'h00E1, 16'h00ED, 16'h00F3, 16'h00FA, 16'h00F1, 16'h00D1, 16'h00AA, 16'h00BA,
    16'h00BF, 16'h2310, 16'h00AC, 16'h00BD, 16'h00BC, 16'h00A1, 16'h00AB, 16'h00BB,
    16'h2591, 16'h2592, 16'h2593, 16'h2502, 16'h2524, 16'h2561, 16'h2562, 16'h2556,
    16'h2555, 16'h2563, 16'h2551, 16'h2557, 16'h255D, 16'h255C, 16'h255B, 16'h2510,
    16'h2514, 16'h2534, 16'h252C, 16'h251C, 16'h2500, 16'h253C, 16'h255E, 16'h255F,
    16'h255A, 16'h2554, 16'h2569, 16'h2566, 16'h2560, 16'h2550, 16'h256C, 16'h2567,
    16'h2568, 16'h2564, 16'h2565, 16'h2559, 16'h2558, 16'h2552, 16'h2553, 16'h256B,
    16'h256A, 16'h2518, 16'h250C, 16'h2588, 16'h2584, 16'h258C, 16'h2590, 16'h2580,
    16'h03B1, 16'h00DF, 16'h0393, 16'h03C0, 16'h03A3, 16'h03C3, 16'h00B5, 16'h03C4,
    16'h03A6, 16'h0398, 16'h03A9, 16'h03B4, 16'h221E, 16'h03C6, 16'h03B5, 16'h2229,
    16'h2261, 16'h00B1, 16'h2265, 16'h2264, 16'h2320, 16'h2321, 16'h00F7, 16'h2248,
    16'h00B0, 16'h2219, 16'h00B7, 16'h221A, 16'h207F, 16'h00B2, 16'h25A0, 16'h00A0
  };

endpackage

// ----- design/u2c_decode.sv -----
// UTF-8 sequence decoder: holds the partial code point and sequence state,
// and describes the results each accepted byte causes.
// Depends on u2c_pkg.
module u2c_decode (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              accept_i,
  input  logic [7:0]        text_byte_i,
  input  logic              end_of_string_i,
  output u2c_pkg::u2c_res_t res_o
);
  import u2c_pkg::*;

  logic [CpWidth-1:0] pcp_q, pcp_d;
  logic [1:0]         rem_q, rem_d;
  logic               start_q, start_d;

  logic               is_cont;
  logic               pre_none;
  logic               main_vld;
  logic               main_cp;
  logic [CpWidth-1:0] main_val;
  logic [CpWidth-1:0] shifted;

  assign is_cont = (text_byte_i & ContMask) == ContMark;
  assign shifted = {pcp_q[CpWidth-7:0], text_byte_i[5:0]};

  always_comb begin
    pcp_d    = pcp_q;
    rem_d    = rem_q;
    start_d  = 1'b0;
    pre_none = 1'b0;
    main_vld = 1'b0;
    main_cp  = 1'b0;
    main_val = '0;
    if (is_cont) begin
      if (rem_q != 2'd0) begin
        pcp_d = shifted;
        rem_d = 2'(rem_q - 2'd1);
        if (rem_q == 2'd1) begin
          main_vld = 1'b1;
          main_cp  = 1'b1;
          main_val = shifted;
          pcp_d    = '0;
        end
      end else if (start_q) begin
        main_vld = 1'b1;
      end
    end else begin
      // a new non-continuation byte cuts off a pending sequence
      pre_none = rem_q != 2'd0;
      rem_d    = 2'd0;
      pcp_d    = '0;
      if (!text_byte_i[7]) begin
        main_vld = 1'b1;
        main_cp  = 1'b1;
        main_val = CpWidth'(text_byte_i);
      end else if ((text_byte_i & Lead2Mask) == ContMask) begin
        pcp_d = CpWidth'(text_byte_i & Lead2Bits);
        rem_d = 2'd1;
      end else if ((text_byte_i & Lead3Mask) == Lead3Mark) begin
        pcp_d = CpWidth'(text_byte_i & Lead3Bits);
        rem_d = 2'd2;
      end else if ((text_byte_i & Lead4Mask) == Lead4Mark) begin
        pcp_d = CpWidth'(text_byte_i & Lead4Bits);
        rem_d = 2'd3;
      end else begin
        main_vld = 1'b1;
      end
    end
    if (end_of_string_i) begin
      // string ends mid-sequence: report it in the main slot, which is free then
      if (rem_d != 2'd0) begin
        main_vld = 1'b1;
      end
      rem_d   = 2'd0;
      pcp_d   = '0;
      start_d = 1'b1;
    end
  end

  always_comb begin
    res_o.any   = pre_none | main_vld;
    res_o.two   = pre_none & main_vld;
    res_o.is_cp = main_vld & main_cp;
    res_o.cp    = main_val;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pcp_q   <= '0;
      rem_q   <= 2'd0;
      start_q <= 1'b1;
    end else if (accept_i) begin
      pcp_q   <= pcp_d;
      rem_q   <= rem_d;
      start_q <= start_d;
    end
  end

endmodule

// ----- design/u2c_lookup.sv -----
// Code point to CP437 glyph mapping: a compare bank over entries 1 to 255 of the 256-entry table.
// Newline and unmapped code points get their own kinds.
// Depends on u2c_pkg.
module u2c_lookup (
  input  logic                        is_cp_i,
  input  logic [u2c_pkg::CpWidth-1:0] cp_i,
  output logic [7:0]                  glyph_o,
  output u2c_pkg::kind_e              kind_o
);
  import u2c_pkg::*;

  logic       hit;
  logic [7:0] idx;
  logic       low16;

  assign low16 = cp_i[CpWidth-1:16] == '0;

  // table entries are distinct, so an OR of the matching indexes is the match
  always_comb begin
    hit = 1'b0;
    idx = 8'd0;
    for (int i = 1; i < 256; i++) begin
      if (low16 && (cp_i[15:0] == GLYPH_CP[i])) begin
        hit = 1'b1;
        idx = idx | 8'(i);
      end
    end
  end

  always_comb begin
    glyph_o = 8'd0;
    kind_o  = KIND_NONE;
    if (is_cp_i) begin
      if (cp_i == NewlineCp) begin
        kind_o = KIND_NEWLINE;
      end else if (hit) begin
        glyph_o = idx;
        kind_o  = KIND_GLYPH;
      end
    end
  end

endmodule

// ----- design/utf8_to_cp437_transcoder.sv -----
// UTF-8 to CP437 transcoder, top level. A result goes through the decode register,
// then the output register after the table lookup. Throughput: one byte per cycle
// while the output is not stalled; a byte that causes two results holds the decode
// register until its second result is emitted. Bytes with no result give no output
// item. Reset clears the sequence state and empties both registers.
module utf8_to_cp437_transcoder (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] text_byte_i,
  input  logic       end_of_string_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] glyph_index_o,
  output logic [1:0] char_kind_o,
  output logic       last_of_run_o
);
  import u2c_pkg::*;

  u2c_res_t res;
  u2c_res_t dec_q;
  logic     dec_valid_q;
  logic     phase_q;

  logic     accept;
  logic     out_free;
  logic     emit;
  logic     first_half;
  logic     done;

  logic [7:0] lk_glyph;
  kind_e      lk_kind;

  logic       out_valid_q;
  logic [7:0] glyph_q;
  kind_e      kind_q;
  logic       last_q;

  assign out_free   = !out_valid_q || out_ready_i;
  assign emit       = dec_valid_q && out_free;
  assign first_half = dec_q.two && !phase_q;
  assign done       = emit && !first_half;
  assign in_ready_o = !dec_valid_q || done;
  assign accept     = in_valid_i && in_ready_o;

  u2c_decode u_decode (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .accept_i       (accept),
    .text_byte_i    (text_byte_i),
    .end_of_string_i(end_of_string_i),
    .res_o          (res)
  );

  u2c_lookup u_lookup (
    .is_cp_i(dec_q.is_cp),
    .cp_i   (dec_q.cp),
    .glyph_o(lk_glyph),
    .kind_o (lk_kind)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dec_valid_q <= 1'b0;
      phase_q     <= 1'b0;
    end else if (accept) begin
      dec_valid_q <= res.any;
      phase_q     <= 1'b0;
    end else if (done) begin
      dec_valid_q <= 1'b0;
    end else if (emit) begin
      phase_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      dec_q <= res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // first of two results is always the no-glyph for a cut-off sequence
  always_ff @(posedge clk_i) begin
    if (emit) begin
      glyph_q <= first_half ? 8'd0 : lk_glyph;
      kind_q  <= first_half ? KIND_NONE : lk_kind;
      last_q  <= !first_half;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign glyph_index_o = glyph_q;
  assign char_kind_o   = kind_q;
  assign last_of_run_o = last_q;

endmodule

// ----- tb/sv/glyph_stream_checker.sv -----
// Checker for the UTF-8 to CP437 transcoder: watches both channels, predicts the glyph
// results of every accepted byte and compares them with what the block returns.
// Depends on u2c_pkg for the result kinds, the decode constants and the code point table.
module glyph_stream_checker (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic       in_ready_i,
  input  logic [7:0] text_byte_i,
  input  logic       end_of_string_i,
  input  logic       out_valid_i,
  input  logic       out_ready_i,
  input  logic [7:0] glyph_index_i,
  input  logic [1:0] char_kind_i,
  input  logic       last_of_run_i,
  output int         err_count_o,
  output int         pending_o,
  output int         checked_o
);
  timeunit 1ns;
  timeprecision 1ps;

  import u2c_pkg::*;

  typedef struct packed {
    logic [7:0] glyph;
    kind_e      kind;
    logic       last;
  } glyph_res_t;

  localparam glyph_res_t NoGlyph = '{glyph: 8'd0, kind: KIND_NONE, last: 1'b0};

  glyph_res_t         expected_glyphs[$];
  glyph_res_t         want;
  logic [CpWidth-1:0] cp_acc;
  logic [1:0]         cont_left;
  logic               fresh_string;
  int                 mismatches;
  int                 checked;

  function automatic glyph_res_t lookup_glyph(logic [CpWidth-1:0] cp);
    glyph_res_t r;
    r = NoGlyph;
    if (cp == NewlineCp) begin
      r.kind = KIND_NEWLINE;
    end else begin
      // Walk down so the lowest matching index wins; index 0 never yields a glyph.
      for (int i = 255; i >= 1; i--) begin
        if ({5'd0, GLYPH_CP[i]} == cp) begin
          r.glyph = 8'(i);
          r.kind  = KIND_GLYPH;
        end
      end
    end
    return r;
  endfunction

  function automatic void decode_byte(logic [7:0] b, logic eos);
    glyph_res_t res[$];
    if ((b & ContMask) == ContMark) begin
      if (cont_left != 2'd0) begin
        cp_acc    = {cp_acc[CpWidth-7:0], b[5:0]};
        cont_left = cont_left - 2'd1;
        if (cont_left == 2'd0) begin
          res.push_back(lookup_glyph(cp_acc));
          cp_acc = '0;
        end
      end else if (fresh_string) begin
        res.push_back(NoGlyph);
      end
    end else begin
      // A new lead or ASCII byte aborts any pending sequence first.
      if (cont_left != 2'd0) begin
        res.push_back(NoGlyph);
        cont_left = 2'd0;
        cp_acc    = '0;
      end
      if (!b[7]) begin
        res.push_back(lookup_glyph({13'd0, b}));
      end else if ((b & Lead2Mask) == ContMask) begin
        cp_acc    = {13'd0, b & Lead2Bits};
        cont_left = 2'd1;
      end else if ((b & Lead3Mask) == Lead3Mark) begin
        cp_acc    = {13'd0, b & Lead3Bits};
        cont_left = 2'd2;
      end else if ((b & Lead4Mask) == Lead4Mark) begin
        cp_acc    = {13'd0, b & Lead4Bits};
        cont_left = 2'd3;
      end else begin
        res.push_back(NoGlyph);
      end
    end
    fresh_string = 1'b0;
    if (eos) begin
      if (cont_left != 2'd0) res.push_back(NoGlyph);
      cont_left    = 2'd0;
      cp_acc       = '0;
      fresh_string = 1'b1;
    end
    if (res.size() > 0) res[res.size()-1].last = 1'b1;
    foreach (res[i]) expected_glyphs.push_back(res[i]);
  endfunction

  function automatic void check_field(string name, int exp_val, int act_val);
    if (exp_val != act_val) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, exp_val, act_val);
      mismatches++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      expected_glyphs.delete();
      cp_acc       = '0;
      cont_left    = 2'd0;
      fresh_string = 1'b1;
      mismatches   = 0;
      checked      = 0;
    end else begin
      if (in_valid_i && in_ready_i) decode_byte(text_byte_i, end_of_string_i);
      if (out_valid_i && out_ready_i) begin
        if (expected_glyphs.size() == 0) begin
          $display("%0t: unexpected result, expected none, got glyph %0h kind %0d last %0b",
                   $time, glyph_index_i, char_kind_i, last_of_run_i);
          mismatches++;
        end else begin
          want = expected_glyphs.pop_front();
          check_field("glyph_index", want.glyph, glyph_index_i);
          check_field("char_kind", want.kind, char_kind_i);
          check_field("last_of_run", want.last, last_of_run_i);
          checked++;
        end
      end
    end
    err_count_o <= mismatches;
    pending_o   <= expected_glyphs.size();
    checked_o   <= checked;
  end

endmodule

// ----- tb/sv/tb_utf8_to_cp437_transcoder.sv -----
// Top of the transcoder testbench: clock, reset, byte stimulus, output stalls and verdict.
// Depends on utf8_to_cp437_transcoder and glyph_stream_checker.
module tb_utf8_to_cp437_transcoder;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ClkPeriod  = 8;
  localparam int ItemTarget = 940;
  localparam int IdleLimit  = 2000;

  // Opening strings, {end_of_string, text_byte}.
  localparam logic [8:0] OpeningBytes [26] = '{
    9'h080, 9'h0bf, 9'h041, 9'h00a, 9'h17f,
    9'h0ff, 9'h080, 9'h120,
    9'h0c3, 9'h0a9, 9'h0c2, 9'h0a0, 9'h0e2, 9'h098, 9'h0ba,
    9'h0f0, 9'h09f, 9'h098, 9'h080, 9'h0c3, 9'h041, 9'h001,
    9'h000, 9'h0f8, 9'h0e2, 9'h195
  };

  logic       clk_i           = 1'b0;
  logic       rst_ni          = 1'b0;
  logic       in_valid_i      = 1'b0;
  logic [7:0] text_byte_i     = 8'd0;
  logic       end_of_string_i = 1'b0;
  logic       out_ready_i     = 1'b0;
  logic       in_ready_o;
  logic       out_valid_o;
  logic [7:0] glyph_index_o;
  logic [1:0] char_kind_o;
  logic       last_of_run_o;

  int         err_count;
  int         pending;
  int         checked;
  int         bytes_sent;
  int         strings_sent;
  int         burst_left;
  int         idle_cycles;
  int         stall_mode;
  int         stall_left;
  logic [7:0] str_bytes[$];

  always #(ClkPeriod / 2) clk_i = ~clk_i;

  utf8_to_cp437_transcoder i_dut (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_ready_o,
    .text_byte_i,
    .end_of_string_i,
    .out_valid_o,
    .out_ready_i,
    .glyph_index_o,
    .char_kind_o,
    .last_of_run_o
  );

  glyph_stream_checker i_checker (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_ready_i     (in_ready_o),
    .text_byte_i,
    .end_of_string_i,
    .out_valid_i    (out_valid_o),
    .out_ready_i,
    .glyph_index_i  (glyph_index_o),
    .char_kind_i    (char_kind_o),
    .last_of_run_i  (last_of_run_o),
    .err_count_o    (err_count),
    .pending_o      (pending),
    .checked_o      (checked)
  );

  // Receiver: switch between always ready, coin flip, mostly stalled and a fixed pattern.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      stall_mode  <= 0;
      stall_left  <= 0;
    end else begin
      if (stall_left == 0) begin
        stall_mode <= $urandom_range(0, 3);
        stall_left <= $urandom_range(16, 96);
      end else begin
        stall_left <= stall_left - 1;
      end
      case (stall_mode)
        0: out_ready_i <= 1'b1;
        1: out_ready_i <= 1'($urandom_range(0, 1));
        2: out_ready_i <= ($urandom_range(0, 3) == 0);
        default: out_ready_i <= (stall_left % 5) > 1;
      endcase
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= IdleLimit) begin
        $display("%0t: no handshake for %0d cycles", $time, IdleLimit);
        $display("Verification failed");
        $finish;
      end
    end else begin
      idle_cycles <= 0;
    end
  end

  task automatic push_byte(input logic [7:0] b, input logic eos);
    if (burst_left == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
      burst_left = $urandom_range(1, 40);
    end
    in_valid_i      <= 1'b1;
    text_byte_i     <= b;
    end_of_string_i <= eos;
    do @(posedge clk_i); while (!in_ready_o);
    burst_left--;
    bytes_sent++;
  endtask

  // Hold the sender until every expected result has come back.
  task automatic drain_results();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    burst_left = 0;
  endtask

  function automatic void add_code_point(logic [20:0] cp);
    if (cp < 21'h80) begin
      str_bytes.push_back(cp[7:0]);
    end else if (cp < 21'h800) begin
      str_bytes.push_back({3'b110, cp[10:6]});
      str_bytes.push_back({2'b10, cp[5:0]});
    end else begin
      str_bytes.push_back({4'b1110, cp[15:12]});
      str_bytes.push_back({2'b10, cp[11:6]});
      str_bytes.push_back({2'b10, cp[5:0]});
    end
  endfunction

  function automatic void add_char();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 30) begin
      str_bytes.push_back(8'($urandom_range(8'h20, 8'h7e)));
    end else if (pick < 36) begin
      str_bytes.push_back(8'h0a);
    end else if (pick < 42) begin
      str_bytes.push_back(8'($urandom_range(8'h01, 8'h1f)));
    end else if (pick < 62) begin
      add_code_point({5'd0, u2c_pkg::GLYPH_CP[$urandom_range(1, 255)]});
    end else if (pick < 72) begin
      str_bytes.push_back({3'b110, 5'($urandom)});
      str_bytes.push_back({2'b10, 6'($urandom)});
    end else if (pick < 80) begin
      str_bytes.push_back({4'b1110, 4'($urandom)});
      repeat (2) str_bytes.push_back({2'b10, 6'($urandom)});
    end else if (pick < 86) begin
      str_bytes.push_back({5'b11110, 3'($urandom)});
      repeat (3) str_bytes.push_back({2'b10, 6'($urandom)});
    end else if (pick < 90) begin
      // Lead byte followed by zero or one continuation, too few unless it is a two-byte lead.
      str_bytes.push_back(8'($urandom_range(8'hc0, 8'hf7)));
      repeat ($urandom_range(0, 1)) str_bytes.push_back({2'b10, 6'($urandom)});
    end else if (pick < 94) begin
      str_bytes.push_back({2'b10, 6'($urandom)});
    end else if (pick < 97) begin
      str_bytes.push_back(8'($urandom_range(8'hf8, 8'hff)));
    end else begin
      str_bytes.push_back(8'($urandom_range(1, 255)));
    end
  endfunction

  initial begin
    bytes_sent   = 0;
    strings_sent = 0;
    burst_left   = 0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (OpeningBytes[i]) begin
      push_byte(OpeningBytes[i][7:0], OpeningBytes[i][8]);
      if (OpeningBytes[i][8]) strings_sent++;
    end
    drain_results();

    while (bytes_sent < ItemTarget) begin
      str_bytes.delete();
      repeat ($urandom_range(1, 10)) add_char();
      foreach (str_bytes[i]) push_byte(str_bytes[i], i == str_bytes.size() - 1);
      strings_sent++;
      if (strings_sent % 25 == 0) drain_results();
    end

    drain_results();
    repeat (8) @(posedge clk_i);
    $display("Covered %0d bytes in %0d strings; %0d results compared, %0d mismatches",
             bytes_sent, strings_sent, checked, err_count);
    if (err_count == 0 && pending == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
